### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Flag a condition that must never hold at a clock edge
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Flag a consequent that fails when its antecedent holds
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/core/lzss_pkg.sv
// ----------------------------------------------------------------------------
// LZSS chunk decoder package
// Shared constants, codes and the command passed from front to back.
// ----------------------------------------------------------------------------
package lzss_pkg;

    localparam int SIZE_BITS_DEF = 24;
    localparam int WINDOW_BYTES  = 4096;
    localparam int WIN_AW        = $clog2(WINDOW_BYTES);
    localparam int LEN_W         = 5;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0]        SPACE_BYTE = 8'h20;
    localparam logic [WIN_AW-1:0] POS_BIAS   = WIN_AW'(8'h12);
    localparam logic [LEN_W-1:0]  LEN_BIAS   = LEN_W'(3);

    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT_KEY,
        ST_SHORT_LIT,
        ST_SHORT_PAIR,
        ST_OVERFLOW,
        ST_TOO_FAR,
        ST_EXTRA,
        ST_PAD
    } status_t;

    typedef enum logic [1:0] {
        PH_KEY,
        PH_ITEM,
        PH_HIGH
    } phase_t;

    typedef enum logic {
        REG_COMPRESSED_SIZE,
        REG_UNCOMPRESSED_SIZE
    } cfg_reg_t;

    typedef enum logic {
        CMD_SINGLE,
        CMD_COPY
    } cmd_kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_COPY
    } back_state_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic              hist_wr;
        logic [7:0]        data;
        status_t           status;
        logic              done;
        logic [WIN_AW-1:0] src;
        logic [LEN_W-1:0]  neg;
        logic [LEN_W-1:0]  len;
        logic [WIN_AW-1:0] dst;
    } cmd_t;

endpackage

### rtl/core/lzss_ram.sv
// ----------------------------------------------------------------------------
// LZSS generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/lzss_front.sv
// ----------------------------------------------------------------------------
// LZSS front end
// Holds the size registers, parses key bytes, literals and pairs, and
// issues one command per input byte that yields results.
// ----------------------------------------------------------------------------
module lzss_front
    import lzss_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [0:0]           cfg_index,
    input  logic [SIZE_BITS-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    output logic                 q_push,
    output cmd_t                 q_cmd,
    input  logic                 q_full
);

    logic [SIZE_BITS-1:0] csize_reg, csize_next;
    logic [SIZE_BITS-1:0] usize_reg, usize_next;
    logic [SIZE_BITS-1:0] in_cnt_reg, in_cnt_next;
    logic [SIZE_BITS-1:0] out_cnt_reg, out_cnt_next;
    logic [7:0]           flag_byte_reg, flag_byte_next;
    logic [2:0]           flag_idx_reg, flag_idx_next;
    phase_t               phase_reg, phase_next;
    logic [7:0]           pair_low_reg, pair_low_next;
    status_t              err_reg, err_next;

    logic                 cfg_wr;
    logic                 accept;
    logic                 passthru;
    logic                 out_reached;
    logic [SIZE_BITS-1:0] in_cnt_inc;
    logic                 last;
    logic [WIN_AW-1:0]    p12;
    logic [LEN_W-1:0]     len;
    logic [SIZE_BITS:0]   out_sum;
    logic                 overflow;
    logic                 neg;
    logic [WIN_AW:0]      neg_dist;
    logic                 too_far;
    logic [2:0]           fi_adv;
    phase_t               ph_adv;
    status_t              fault;
    status_t              s_end;
    logic                 produce;

    function automatic status_t end_status(input logic       reached,
                                           input logic [7:0] fb,
                                           input logic [2:0] fi,
                                           input phase_t     ph);
        status_t s;
        if (reached)
        begin
            s = (fi != 3'd0 && (fb >> fi) != 8'd0) ? ST_PAD : ST_OK;
        end
        else
        begin
            case (ph)
                PH_KEY:  s = ST_SHORT_KEY;
                PH_HIGH: s = ST_SHORT_PAIR;
                default: s = fb[fi] ? ST_SHORT_LIT : ST_SHORT_PAIR;
            endcase
        end
        return s;
    endfunction

    assign cfg_ready   = 1'b1;
    assign in_ready    = !q_full;
    assign cfg_wr      = cfg_valid && cfg_ready;
    assign accept      = in_valid && in_ready;
    assign passthru    = (csize_reg == usize_reg);
    assign out_reached = (out_cnt_reg >= usize_reg);
    assign in_cnt_inc  = in_cnt_reg + SIZE_BITS'(1);
    assign last        = (in_cnt_inc == csize_reg);

    assign p12      = WIN_AW'(pair_low_reg) + {in_byte[7:4], 8'h00} + POS_BIAS;
    assign len      = LEN_W'(in_byte[3:0]) + LEN_BIAS;
    assign out_sum  = {1'b0, out_cnt_reg} + (SIZE_BITS+1)'(len);
    assign overflow = (out_sum > {1'b0, usize_reg});
    assign neg      = (out_cnt_reg[SIZE_BITS-1:WIN_AW] == '0)
                      && (p12 >= out_cnt_reg[WIN_AW-1:0]);
    assign neg_dist = (WIN_AW+1)'(WINDOW_BYTES) - {1'b0, p12};
    assign too_far  = neg && (neg_dist > (WIN_AW+1)'(len));
    assign fi_adv   = flag_idx_reg + 3'd1;
    assign ph_adv   = (fi_adv == 3'd0) ? PH_KEY : PH_ITEM;

    always_comb
    begin
        csize_next     = csize_reg;
        usize_next     = usize_reg;
        in_cnt_next    = in_cnt_reg;
        out_cnt_next   = out_cnt_reg;
        flag_byte_next = flag_byte_reg;
        flag_idx_next  = flag_idx_reg;
        phase_next     = phase_reg;
        pair_low_next  = pair_low_reg;
        err_next       = err_reg;
        fault          = ST_OK;
        s_end          = ST_OK;
        produce        = 1'b0;
        q_push         = 1'b0;
        q_cmd.kind     = CMD_SINGLE;
        q_cmd.hist_wr  = 1'b0;
        q_cmd.data     = 8'd0;
        q_cmd.status   = ST_OK;
        q_cmd.done     = 1'b0;
        q_cmd.src      = p12;
        q_cmd.neg      = neg ? neg_dist[LEN_W-1:0] : '0;
        q_cmd.len      = len;
        q_cmd.dst      = out_cnt_reg[WIN_AW-1:0];

        if (cfg_wr)
        begin
            if (cfg_index == REG_COMPRESSED_SIZE)
            begin
                csize_next = cfg_data;
            end
            else
            begin
                usize_next = cfg_data;
            end
            in_cnt_next    = '0;
            out_cnt_next   = '0;
            flag_byte_next = 8'd0;
            flag_idx_next  = 3'd0;
            phase_next     = PH_KEY;
            pair_low_next  = 8'd0;
            err_next       = ST_OK;
        end
        else if (accept)
        begin
            if (err_reg != ST_OK)
            begin
                q_push       = 1'b1;
                q_cmd.status = err_reg;
            end
            else if (in_cnt_reg >= csize_reg)
            begin
                s_end = passthru ? ST_OK
                        : end_status(out_reached, flag_byte_reg, flag_idx_reg, phase_reg);
                if (s_end == ST_OK)
                begin
                    s_end = ST_EXTRA;
                end
                err_next     = s_end;
                q_push       = 1'b1;
                q_cmd.status = s_end;
            end
            else if (passthru)
            begin
                in_cnt_next = in_cnt_inc;
                q_push      = 1'b1;
                q_cmd.data  = in_byte;
                q_cmd.done  = last;
            end
            else if (out_reached)
            begin
                err_next     = ST_EXTRA;
                q_push       = 1'b1;
                q_cmd.status = ST_EXTRA;
            end
            else
            begin
                in_cnt_next = in_cnt_inc;
                case (phase_reg)
                    PH_KEY:
                    begin
                        flag_byte_next = in_byte;
                        phase_next     = PH_ITEM;
                    end
                    PH_ITEM:
                    begin
                        if (flag_byte_reg[flag_idx_reg])
                        begin
                            out_cnt_next  = out_cnt_reg + SIZE_BITS'(1);
                            flag_idx_next = fi_adv;
                            phase_next    = ph_adv;
                            produce       = 1'b1;
                            q_cmd.hist_wr = 1'b1;
                            q_cmd.data    = in_byte;
                        end
                        else
                        begin
                            pair_low_next = in_byte;
                            phase_next    = PH_HIGH;
                        end
                    end
                    default:
                    begin
                        if (overflow)
                        begin
                            fault = ST_OVERFLOW;
                        end
                        else if (too_far)
                        begin
                            fault = ST_TOO_FAR;
                        end
                        else
                        begin
                            out_cnt_next  = out_sum[SIZE_BITS-1:0];
                            flag_idx_next = fi_adv;
                            phase_next    = ph_adv;
                            produce       = 1'b1;
                            q_cmd.kind    = CMD_COPY;
                        end
                    end
                endcase

                if (fault == ST_OK && last)
                begin
                    fault = end_status(out_cnt_next >= usize_reg, flag_byte_next,
                                       flag_idx_next, phase_next);
                end

                if (fault != ST_OK)
                begin
                    err_next      = fault;
                    q_push        = 1'b1;
                    q_cmd.kind    = CMD_SINGLE;
                    q_cmd.hist_wr = 1'b0;
                    q_cmd.data    = 8'd0;
                    q_cmd.status  = fault;
                end
                else if (produce)
                begin
                    q_push     = 1'b1;
                    q_cmd.done = last;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csize_reg     <= '0;
            usize_reg     <= '0;
            in_cnt_reg    <= '0;
            out_cnt_reg   <= '0;
            flag_byte_reg <= 8'd0;
            flag_idx_reg  <= 3'd0;
            phase_reg     <= PH_KEY;
            pair_low_reg  <= 8'd0;
            err_reg       <= ST_OK;
        end
        else
        begin
            csize_reg     <= csize_next;
            usize_reg     <= usize_next;
            in_cnt_reg    <= in_cnt_next;
            out_cnt_reg   <= out_cnt_next;
            flag_byte_reg <= flag_byte_next;
            flag_idx_reg  <= flag_idx_next;
            phase_reg     <= phase_next;
            pair_low_reg  <= pair_low_next;
            err_reg       <= err_next;
        end
    end

endmodule

### rtl/core/lzss_cmd_queue.sv
// ----------------------------------------------------------------------------
// LZSS command queue
// Short FIFO of decoded commands between the front and back ends.
// ----------------------------------------------------------------------------
module lzss_cmd_queue
    import lzss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/lzss_back.sv
// ----------------------------------------------------------------------------
// LZSS back end
// Executes commands: emits single results, runs history copies one byte per
// cycle when not stalled; keeps the history window and the output register.
// ----------------------------------------------------------------------------
module lzss_back
    import lzss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  cmd_t       q_head,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       chunk_done,
    output logic [2:0] status
);

    back_state_t       state_reg, state_next;
    logic [WIN_AW-1:0] src_reg, dst_reg;
    logic [LEN_W-1:0]  neg_reg, rem_reg;
    logic              done_reg;
    logic              fwd_hit_reg;
    logic [7:0]        fwd_data_reg;

    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              run_last_reg;
    logic              chunk_done_reg;
    status_t           status_reg;

    logic              out_free;
    logic              take;
    logic              load;
    logic [7:0]        ld_byte;
    logic              ld_last;
    logic              ld_done;
    status_t           ld_status;
    logic [7:0]        copy_byte;
    logic [WIN_AW-1:0] src_inc;

    logic              ram_we;
    logic [WIN_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [WIN_AW-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    lzss_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_BYTES)
    ) u_history (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign src_inc   = src_reg + WIN_AW'(1);
    assign copy_byte = (neg_reg != '0) ? SPACE_BYTE
                       : (fwd_hit_reg ? fwd_data_reg : ram_rdata);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && q_head.kind == CMD_COPY)
                begin
                    state_next = BK_COPY;
                end
            end
            BK_COPY:
            begin
                if (out_free && rem_reg == LEN_W'(1))
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        take      = 1'b0;
        load      = 1'b0;
        ld_byte   = copy_byte;
        ld_last   = 1'b0;
        ld_done   = 1'b0;
        ld_status = ST_OK;
        ram_we    = 1'b0;
        ram_waddr = dst_reg;
        ram_wdata = copy_byte;
        ram_raddr = src_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_head.kind == CMD_COPY)
                    begin
                        q_pop     = 1'b1;
                        ram_raddr = q_head.src;
                    end
                    else if (out_free)
                    begin
                        q_pop     = 1'b1;
                        load      = 1'b1;
                        ld_byte   = q_head.data;
                        ld_last   = 1'b1;
                        ld_done   = q_head.done;
                        ld_status = q_head.status;
                        ram_we    = q_head.hist_wr;
                        ram_waddr = q_head.dst;
                        ram_wdata = q_head.data;
                    end
                end
            end
            BK_COPY:
            begin
                take = out_free;
                if (take)
                begin
                    load      = 1'b1;
                    ld_last   = (rem_reg == LEN_W'(1));
                    ld_done   = done_reg && (rem_reg == LEN_W'(1));
                    ram_we    = 1'b1;
                    ram_raddr = src_inc;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_IDLE && q_pop && q_head.kind == CMD_COPY)
        begin
            src_reg     <= q_head.src;
            dst_reg     <= q_head.dst;
            neg_reg     <= q_head.neg;
            rem_reg     <= q_head.len;
            done_reg    <= q_head.done;
            fwd_hit_reg <= 1'b0;
        end
        else if (take)
        begin
            src_reg      <= src_inc;
            dst_reg      <= dst_reg + WIN_AW'(1);
            neg_reg      <= (neg_reg != '0) ? neg_reg - LEN_W'(1) : '0;
            rem_reg      <= rem_reg - LEN_W'(1);
            fwd_hit_reg  <= (src_inc == dst_reg);
            fwd_data_reg <= copy_byte;
        end
        else
        begin
            fwd_hit_reg <= 1'b0;
        end

        if (load)
        begin
            out_byte_reg   <= ld_byte;
            run_last_reg   <= ld_last;
            chunk_done_reg <= ld_done;
            status_reg     <= ld_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign run_last   = run_last_reg;
    assign chunk_done = chunk_done_reg;
    assign status     = status_reg;

endmodule

### rtl/core/lzss_chunk_decoder.sv
// ----------------------------------------------------------------------------
// LZSS chunk decoder
// Decodes one chunk of LZSS data (4 KB window) or passes it through.
// ----------------------------------------------------------------------------
// Write compressed_size (index 0) and uncompressed_size (index 1) on the cfg
// channel while idle; either write restarts the chunk. Feed compressed bytes
// on in_valid/in_ready, one byte per transaction. Results leave on
// out_valid/out_ready: out_byte, run_last on the final result of an input
// byte, chunk_done on the last byte of a clean chunk, and a status code that
// once nonzero is held on one result per further input byte.
// A literal, pass-through byte or error reaches out_valid through the command
// queue and the output register; a copy's first byte also passes the BK_COPY
// state and the registered history RAM read. Key bytes and pair low bytes
// yield nothing. The back end streams a copy from the history RAM read port
// one byte per cycle while out_ready does not stall it.
// A two-entry command queue lets the parser run ahead of a copy.
// Reset clears control state and both size registers; the history RAM is
// not cleared, as a copy only reads bytes written earlier in the chunk.
// A stall on out_ready freezes the back end; once the queue fills, in_ready
// drops until the receiver resumes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzss_chunk_decoder
    import lzss_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [0:0]           cfg_index,
    input  logic [SIZE_BITS-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 run_last,
    output logic                 chunk_done,
    output logic [2:0]           status
);

    logic q_push;
    cmd_t q_cmd;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t q_head;

    lzss_front #(
        .SIZE_BITS (SIZE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .q_push    (q_push),
        .q_cmd     (q_cmd),
        .q_full    (q_full)
    );

    lzss_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    lzss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .chunk_done (chunk_done),
        .status     (status)
    );

    `ASSERT_NEVER(a_queue_overflow, q_push && q_full, "command queue overflow")
    `ASSERT_NEVER(a_pop_when_empty, q_pop && q_empty, "command popped from empty queue")
    `ASSERT_IMPLY(a_error_result, out_valid && (status != ST_OK), (out_byte == 8'd0) && run_last && !chunk_done, "malformed error result")
    `ASSERT_IMPLY(a_done_is_last, out_valid && chunk_done, run_last && (status == ST_OK), "chunk_done not on a clean final result")

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS chunk decoder testbench
// Writes both size registers for each chunk, then streams compressed bytes
// through the decoder with random idling on both sides and a long output
// stall. A behavioural decoder predicts every result from the accepted
// bytes; each result is checked field by field against the oldest
// prediction. Directed chunks cover pass-through, literals, copies that
// read before the start of output, every error status and held errors;
// random chunks follow, mostly well-formed streams, some corrupted or noise.
// ----------------------------------------------------------------------------
module tb;
    import lzss_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 360;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
        status_t    st;
    } result_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index  = 1'b0;
    logic [23:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte    = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        chunk_done;
    logic [2:0]  status;

    // decoder state as predicted
    logic [23:0] csize, usize;
    logic [7:0]  key_flags;
    logic [2:0]  flag_pos;
    phase_t      dec_phase;
    logic [7:0]  pair_low;
    longint      in_cnt, out_cnt;
    status_t     held_status;
    logic [7:0]  window [4096];

    result_t     result_q [$];
    result_t     head;
    logic [7:0]  send_q [$];
    logic [7:0]  chunk_bytes [$];
    int          produced, key_at, flags_used;
    logic        in_acc     = 1'b0;
    logic        cfg_acc    = 1'b0;
    int          fail_count = 0;
    int          stall_count = 0;
    int          hold_req   = 0;
    int          hold_seen  = 0;
    int          hold_left  = 0;
    int          send_idle_pct = 26;
    int          recv_idle_pct = 49;
    int          random_sent = 0;

    lzss_chunk_decoder #(.SIZE_BITS(24)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .chunk_done (chunk_done),
        .status     (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void load_size(input cfg_reg_t idx, input logic [23:0] val);
        if (idx == REG_COMPRESSED_SIZE)
            csize = val;
        else
            usize = val;
        key_flags   = '0;
        flag_pos    = '0;
        dec_phase   = PH_KEY;
        pair_low    = '0;
        in_cnt      = 0;
        out_cnt     = 0;
        held_status = ST_OK;
    endfunction

    function automatic void post_error(input status_t s);
        held_status = s;
        result_q.push_back('{data: 8'h00, last: 1'b1, done: 1'b0, st: s});
    endfunction

    function automatic status_t end_code();
        if (out_cnt >= usize) begin
            if (flag_pos != 0 && (key_flags >> flag_pos) != 0)
                return ST_PAD;
            return ST_OK;
        end
        if (dec_phase == PH_KEY)
            return ST_SHORT_KEY;
        if (dec_phase == PH_HIGH)
            return ST_SHORT_PAIR;
        return key_flags[flag_pos] ? ST_SHORT_LIT : ST_SHORT_PAIR;
    endfunction

    function automatic void next_flag();
        flag_pos  = flag_pos + 3'd1;
        dec_phase = (flag_pos == 0) ? PH_KEY : PH_ITEM;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        logic [7:0] run_bytes [$];
        logic [7:0] v;
        logic       last_byte;
        status_t    s;
        longint     len, cur, pos;
        int         n;
        if (held_status != ST_OK) begin
            post_error(held_status);
            return;
        end
        if (in_cnt >= csize) begin
            s = (csize == usize) ? ST_OK : end_code();
            post_error((s == ST_OK) ? ST_EXTRA : s);
            return;
        end
        if (csize == usize) begin
            in_cnt++;
            out_cnt++;
            result_q.push_back('{data: b, last: 1'b1, done: in_cnt == csize, st: ST_OK});
            return;
        end
        if (out_cnt >= usize) begin
            post_error(ST_EXTRA);
            return;
        end
        in_cnt++;
        last_byte = (in_cnt == csize);
        case (dec_phase)
            PH_KEY:
            begin
                key_flags = b;
                dec_phase = PH_ITEM;
            end
            PH_ITEM:
            begin
                if (key_flags[flag_pos]) begin
                    run_bytes.push_back(b);
                    window[out_cnt & 4095] = b;
                    out_cnt++;
                    next_flag();
                end else begin
                    pair_low  = b;
                    dec_phase = PH_HIGH;
                end
            end
            default:
            begin
                len = longint'(b[3:0]) + 3;
                cur = out_cnt;
                pos = (longint'(pair_low) + (longint'(b[7:4]) << 8) + 'h12) & 'hfff;
                if (cur + len > usize) begin
                    post_error(ST_OVERFLOW);
                    return;
                end
                pos = pos + (cur & ~longint'(4095));
                if (pos >= cur)
                    pos = pos - 'h1000;
                if (pos + len < 0) begin
                    post_error(ST_TOO_FAR);
                    return;
                end
                for (longint i = 0; i < len; i++) begin
                    v = (pos < 0) ? SPACE_BYTE : window[pos & 4095];
                    run_bytes.push_back(v);
                    window[out_cnt & 4095] = v;
                    out_cnt++;
                    pos++;
                end
                next_flag();
            end
        endcase
        if (last_byte) begin
            s = end_code();
            if (s != ST_OK) begin
                post_error(s);
                return;
            end
        end
        n = run_bytes.size();
        for (int k = 0; k < n; k++)
            result_q.push_back('{data: run_bytes[k], last: k == n - 1,
                                 done: last_byte && k == n - 1, st: ST_OK});
    endfunction

    // monitor: sample transactions, predict, check, watchdog
    always @(posedge clk)
    begin
        in_acc  <= in_valid && in_ready;
        cfg_acc <= cfg_valid && cfg_ready;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected result: out_byte %h status %0d", out_byte, status);
                    fail_count++;
                end else begin
                    head = result_q.pop_front();
                    if (out_byte !== head.data) begin
                        $error("out_byte: expected %h, got %h", head.data, out_byte);
                        fail_count++;
                    end
                    if (run_last !== head.last) begin
                        $error("run_last: expected %b, got %b", head.last, run_last);
                        fail_count++;
                    end
                    if (chunk_done !== head.done) begin
                        $error("chunk_done: expected %b, got %b", head.done, chunk_done);
                        fail_count++;
                    end
                    if (status !== head.st) begin
                        $error("status: expected %0d, got %0d", head.st, status);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                decode_byte(in_byte);
            if (cfg_valid && cfg_ready)
                load_size(cfg_reg_t'(cfg_index), cfg_data);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT) begin
                $display("** lzss_chunk_decoder: FAILED **");
                $finish;
            end
        end
    end

    // driver: present the next byte once the previous transaction is done
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_acc)) begin
            if (send_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_byte  <= send_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure, plus a long hold on request
    always @(negedge clk)
    begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [23:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge clk); while (!cfg_acc);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (send_q.size() != 0 || in_valid || result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_chunk(input logic [23:0] c, input logic [23:0] u);
        write_reg(REG_COMPRESSED_SIZE, c);
        write_reg(REG_UNCOMPRESSED_SIZE, u);
        foreach (chunk_bytes[i])
            send_q.push_back(chunk_bytes[i]);
        wait_idle();
    endtask

    function automatic logic [15:0] pair_code(input int cur, input int gap, input int len);
        int p;
        p = (cur - gap - 'h12) & 'hfff;
        return {p[7:0], p[11:8], 4'(len - 3)};
    endfunction

    function automatic void build_lzss(input int n_tok, input int pair_pct, input bit long_copy);
        int          len;
        int          gap;
        logic [15:0] code;
        chunk_bytes.delete();
        produced = 0;
        for (int t = 0; t < n_tok; t++) begin
            if (t % 8 == 0) begin
                key_at = chunk_bytes.size();
                chunk_bytes.push_back(8'h00);
            end
            if ($urandom_range(0, 99) >= pair_pct) begin
                chunk_bytes[key_at] = chunk_bytes[key_at] | (8'h01 << (t % 8));
                chunk_bytes.push_back(8'($urandom));
                produced++;
            end else begin
                len = long_copy ? 18 : int'($urandom_range(3, 18));
                if (produced > 0 && $urandom_range(0, 9) < 7)
                    gap = $urandom_range(1, produced);
                else
                    gap = $urandom_range(produced + 1, produced + len);
                code = pair_code(produced, gap, len);
                chunk_bytes.push_back(code[15:8]);
                chunk_bytes.push_back(code[7:0]);
                produced += len;
            end
        end
        flags_used = n_tok % 8;
    endfunction

    function automatic void random_bytes(input int n);
        chunk_bytes.delete();
        repeat (n) chunk_bytes.push_back(8'($urandom));
    endfunction

    task automatic random_chunk();
        int kind;
        int c, u;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3, 4:
            begin
                build_lzss($urandom_range(1, 20), 40, 1'b0);
                c = chunk_bytes.size();
                u = produced;
                if (kind == 4) begin
                    case ($urandom_range(0, 3))
                        0: u = u + $urandom_range(0, 6) - 3;
                        1:
                        begin
                            void'(chunk_bytes.pop_back());
                            c = chunk_bytes.size();
                        end
                        2: repeat ($urandom_range(1, 3)) chunk_bytes.push_back(8'($urandom));
                        default:
                        begin
                            if (flags_used != 0)
                                chunk_bytes[key_at] = chunk_bytes[key_at] | 8'h80;
                            else
                                chunk_bytes.push_back(8'($urandom));
                        end
                    endcase
                    if (u < 0)
                        u = 0;
                end
            end
            5:
            begin
                c = $urandom_range(1, 12);
                u = c;
                random_bytes(c + $urandom_range(0, 1));
            end
            6:
            begin
                c = $urandom_range(0, 20);
                u = $urandom_range(0, 40);
                random_bytes($urandom_range(1, 15));
            end
            7:
            begin
                build_lzss($urandom_range(1, 12), 40, 1'b0);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        c = chunk_bytes.size();
                        u = 24'hFFFFFF;
                    end
                    1:
                    begin
                        c = 24'hFFFFFF;
                        u = produced;
                        repeat (2) chunk_bytes.push_back(8'($urandom));
                    end
                    default:
                    begin
                        c = 24'hFFFFFF;
                        u = 24'hFFFFFF;
                        random_bytes($urandom_range(1, 6));
                    end
                endcase
            end
            default:
            begin
                build_lzss($urandom_range(1, 20), 70, kind == 9);
                c = chunk_bytes.size();
                u = produced;
            end
        endcase
        random_sent += chunk_bytes.size();
        run_chunk(24'(c), 24'(u));
    endtask

    task automatic directed_chunk(input logic [23:0] c, input logic [23:0] u,
                                  input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2, input logic [7:0] b3,
                                  input int n);
        logic [7:0] b [4];
        b = '{b0, b1, b2, b3};
        chunk_bytes.delete();
        for (int i = 0; i < n; i++)
            chunk_bytes.push_back(b[i]);
        run_chunk(c, u);
    endtask

    initial
    begin
        logic [15:0] pc;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // pass-through, then input past the end and a held error
        directed_chunk(2, 2, 8'h00, 8'hFF, 8'h5A, 8'hA5, 4);
        // literal, longest copy partly before the start of output, then extra input
        pc = pair_code(1, 5, 18);
        directed_chunk(4, 19, 8'h01, 8'h41, pc[15:8], pc[7:0], 4);
        directed_chunk(4, 19, 8'h01, 8'h41, pc[15:8], pc[7:0], 4);
        chunk_bytes.delete();
        chunk_bytes.push_back(8'h33);
        foreach (chunk_bytes[i])
            send_q.push_back(chunk_bytes[i]);
        wait_idle();
        // nonzero pad bit
        directed_chunk(2, 1, 8'h03, 8'h7E, 8'h00, 8'h00, 2);
        // input ends before a key, a literal and a pair
        directed_chunk(0, 1, 8'hC3, 8'h00, 8'h00, 8'h00, 1);
        directed_chunk(1, 2, 8'h01, 8'h00, 8'h00, 8'h00, 1);
        directed_chunk(2, 5, 8'h00, 8'h10, 8'h00, 8'h00, 2);
        // shortest copy overflowing the output
        pc = pair_code(0, 1, 3);
        directed_chunk(3, 2, 8'h00, pc[15:8], pc[7:0], 8'h00, 3);
        // copy entirely before the reach of the window
        pc = pair_code(0, 4, 3);
        directed_chunk(3, 10, 8'h00, pc[15:8], pc[7:0], 8'h00, 3);
        // output complete while input remains
        directed_chunk(4, 1, 8'h01, 8'hE7, 8'h99, 8'h00, 3);

        for (int stage = 0; stage < 3; stage++) begin
            send_idle_pct = (stage == 0) ? 26 : (stage == 1) ? 49 : 0;
            recv_idle_pct = (stage == 0) ? 49 : (stage == 1) ? 26 : 0;
            if (stage == 2) begin
                // hold the receiver while long copies queue up
                build_lzss(16, 100, 1'b1);
                random_sent += chunk_bytes.size();
                write_reg(REG_COMPRESSED_SIZE, 24'(chunk_bytes.size()));
                write_reg(REG_UNCOMPRESSED_SIZE, 24'(produced));
                hold_req++;
                foreach (chunk_bytes[i])
                    send_q.push_back(chunk_bytes[i]);
                wait_idle();
            end
            while (random_sent < RANDOM_ITEMS * (stage + 1) / 3)
                random_chunk();
        end

        wait_idle();
        if (fail_count == 0)
            $display("** lzss_chunk_decoder: PASSED **");
        else
            $display("** lzss_chunk_decoder: FAILED **");
        $finish;
    end

endmodule
